[design/sss_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the selection set block.
// No dependencies; imported by every module of the block but sss_ram.
package sss_pkg;

   localparam int LIST_DEPTH = 256;
   localparam int ID_BITS    = 10;
   localparam int IDX_BITS   = $clog2(LIST_DEPTH);
   localparam int CNT_BITS   = IDX_BITS + 1;

   localparam int CMD_BITS   = 3;
   localparam int ROOM_BITS  = 10;
   localparam int COUNT_BITS = 9;

   typedef enum logic [CMD_BITS-1:0] {
      OP_CLEAR   = 3'd0,
      OP_ADD     = 3'd1,
      OP_REMOVE  = 3'd2,
      OP_TOGGLE  = 3'd3,
      OP_QUERY   = 3'd4,
      OP_SAVE    = 3'd5,
      OP_RESTORE = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_COPY_RD,
      ST_COPY_WR
   } state_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_APPEND,
      WR_SHIFT,
      WR_RESTORE
   } wr_sel_type;

   typedef struct packed {
      logic       load;
      logic       idx_inc;
      logic       cnt_clear;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       cnt_from_saved;
      logic       snap_save;
      logic       snap_release;
      logic       rd_next;
      wr_sel_type wr_sel;
      logic       saved_we;
      logic       finish;
      logic       res_present;
      logic       res_changed;
      logic       res_status;
   } dp_cmd_type;

   typedef struct packed {
      op_type op;
      logic   scan_end;
      logic   match;
      logic   shift_end;
      logic   full;
      logic   pending;
   } dp_status_type;

endpackage

[design/sss_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sss_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/sss_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine: sequences scan, shift and snapshot copy.
// Depends on sss_pkg; drives the datapath through dp_cmd_type.
module sss_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  sss_pkg::op_type       command,
   input  sss_pkg::dp_status_type status,
   output logic                  busy,
   output sss_pkg::dp_cmd_type   cmd
);
   import sss_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.wr_sel = WR_NONE;
      busy     = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               case (command)
                  OP_CLEAR: begin
                     cmd.cnt_clear   = 1'b1;
                     cmd.finish      = 1'b1;
                     cmd.res_changed = 1'b1;
                  end
                  OP_ADD, OP_REMOVE, OP_TOGGLE, OP_QUERY: begin
                     state_in = ST_SCAN_RD;
                  end
                  OP_SAVE: begin
                     if (!status.pending) begin
                        cmd.snap_save = 1'b1;
                        state_in      = ST_COPY_RD;
                     end else begin
                        cmd.finish = 1'b1;
                     end
                  end
                  OP_RESTORE: begin
                     if (status.pending) begin
                        cmd.cnt_from_saved = 1'b1;
                        cmd.snap_release   = 1'b1;
                        state_in           = ST_COPY_RD;
                     end else begin
                        cmd.finish = 1'b1;
                     end
                  end
                  default: begin
                     cmd.finish = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN_RD: begin
            if (status.scan_end) begin
               state_in   = ST_IDLE;
               cmd.finish = 1'b1;
               case (status.op)
                  OP_ADD, OP_TOGGLE: begin
                     if (status.full) begin
                        cmd.res_status  = 1'b1;
                        cmd.res_changed = (status.op == OP_TOGGLE);
                     end else begin
                        cmd.wr_sel      = WR_APPEND;
                        cmd.cnt_inc     = 1'b1;
                        cmd.res_present = 1'b1;
                        cmd.res_changed = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end else begin
               state_in = ST_SCAN_CMP;
            end
         end
         ST_SCAN_CMP: begin
            if (status.match) begin
               case (status.op)
                  OP_REMOVE, OP_TOGGLE: begin
                     state_in = ST_SHIFT_RD;
                  end
                  default: begin
                     state_in        = ST_IDLE;
                     cmd.finish      = 1'b1;
                     cmd.res_present = 1'b1;
                  end
               endcase
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_SCAN_RD;
            end
         end
         ST_SHIFT_RD: begin
            if (status.shift_end) begin
               cmd.cnt_dec     = 1'b1;
               cmd.finish      = 1'b1;
               cmd.res_changed = 1'b1;
               state_in        = ST_IDLE;
            end else begin
               cmd.rd_next = 1'b1;
               state_in    = ST_SHIFT_WR;
            end
         end
         ST_SHIFT_WR: begin
            cmd.wr_sel  = WR_SHIFT;
            cmd.idx_inc = 1'b1;
            state_in    = ST_SHIFT_RD;
         end
         ST_COPY_RD: begin
            if (status.scan_end) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               state_in = ST_COPY_WR;
            end
         end
         ST_COPY_WR: begin
            if (status.op == OP_SAVE) begin
               cmd.saved_we = 1'b1;
            end else begin
               cmd.wr_sel = WR_RESTORE;
            end
            cmd.idx_inc = 1'b1;
            state_in    = ST_COPY_RD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[design/sss_datapath.sv]
`timescale 1ns / 1ps
// Datapath: list and snapshot RAMs, counters, compare and result registers.
// Depends on sss_pkg and sss_ram; controlled through dp_cmd_type.
module sss_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [sss_pkg::CMD_BITS-1:0]     req_command,
   input  logic [sss_pkg::ROOM_BITS-1:0]    req_room,
   input  sss_pkg::dp_cmd_type              cmd,
   output sss_pkg::dp_status_type           status,
   output logic                             rsp_valid,
   output logic                             rsp_present,
   output logic                             rsp_changed,
   output logic [sss_pkg::COUNT_BITS-1:0]   rsp_count,
   output logic                             rsp_status
);
   import sss_pkg::*;

   logic [CMD_BITS-1:0] op_ff;
   logic [ID_BITS-1:0]  id_ff;
   logic [CNT_BITS-1:0] index_ff;
   logic [CNT_BITS-1:0] count_ff;
   logic [CNT_BITS-1:0] saved_count_ff;
   logic                pending_ff;
   logic                valid_ff;
   logic                present_ff;
   logic                changed_ff;
   logic                status_ff;

   logic [ID_BITS-1:0]  ent_rdata;
   logic [ID_BITS-1:0]  sav_rdata;
   logic [IDX_BITS-1:0] ent_rd_addr;
   logic [IDX_BITS-1:0] ent_wr_addr;
   logic [ID_BITS-1:0]  ent_wr_data;
   logic                ent_we;
   logic [CNT_BITS:0]   next_index;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_command;
         id_ff <= req_room[ID_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff       <= '0;
         count_ff       <= '0;
         saved_count_ff <= '0;
         pending_ff     <= 1'b0;
         valid_ff       <= 1'b0;
      end else begin
         if (cmd.load) begin
            index_ff <= '0;
         end else if (cmd.idx_inc) begin
            index_ff <= index_ff + CNT_BITS'(1);
         end
         if (cmd.cnt_clear) begin
            count_ff <= '0;
         end else if (cmd.cnt_inc) begin
            count_ff <= count_ff + CNT_BITS'(1);
         end else if (cmd.cnt_dec) begin
            count_ff <= count_ff - CNT_BITS'(1);
         end else if (cmd.cnt_from_saved) begin
            count_ff <= saved_count_ff;
         end
         if (cmd.snap_save) begin
            saved_count_ff <= count_ff;
            pending_ff     <= 1'b1;
         end else if (cmd.snap_release) begin
            pending_ff <= 1'b0;
         end
         valid_ff <= cmd.finish;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         present_ff <= cmd.res_present;
         changed_ff <= cmd.res_changed;
         status_ff  <= cmd.res_status;
      end
   end

   assign next_index  = {1'b0, index_ff} + (CNT_BITS + 1)'(1);
   assign ent_rd_addr = cmd.rd_next ? next_index[IDX_BITS-1:0] : index_ff[IDX_BITS-1:0];
   assign ent_we      = (cmd.wr_sel != WR_NONE);

   always_comb begin
      case (cmd.wr_sel)
         WR_APPEND: begin
            ent_wr_addr = count_ff[IDX_BITS-1:0];
            ent_wr_data = id_ff;
         end
         WR_SHIFT: begin
            ent_wr_addr = index_ff[IDX_BITS-1:0];
            ent_wr_data = ent_rdata;
         end
         default: begin
            ent_wr_addr = index_ff[IDX_BITS-1:0];
            ent_wr_data = sav_rdata;
         end
      endcase
   end

   sss_ram #(
      .WIDTH(ID_BITS),
      .DEPTH(LIST_DEPTH)
   ) u_list_ram (
      .clock  (clock),
      .we     (ent_we),
      .wr_addr(ent_wr_addr),
      .wr_data(ent_wr_data),
      .rd_addr(ent_rd_addr),
      .rd_data(ent_rdata)
   );

   sss_ram #(
      .WIDTH(ID_BITS),
      .DEPTH(LIST_DEPTH)
   ) u_snap_ram (
      .clock  (clock),
      .we     (cmd.saved_we),
      .wr_addr(index_ff[IDX_BITS-1:0]),
      .wr_data(ent_rdata),
      .rd_addr(index_ff[IDX_BITS-1:0]),
      .rd_data(sav_rdata)
   );

   assign status.op        = op_type'(op_ff);
   assign status.scan_end  = (index_ff == count_ff);
   assign status.match     = (ent_rdata == id_ff);
   assign status.shift_end = (next_index >= {1'b0, count_ff});
   assign status.full      = (count_ff == CNT_BITS'(LIST_DEPTH));
   assign status.pending   = pending_ff;

   assign rsp_valid   = valid_ff;
   assign rsp_present = present_ff;
   assign rsp_changed = changed_ff;
   assign rsp_count   = COUNT_BITS'(count_ff);
   assign rsp_status  = status_ff;

endmodule

[design/selection_set_with_snapshot_top.sv]
`timescale 1ns / 1ps
// Top level of the ordered selection set with one snapshot.
// Depends on sss_pkg, sss_ctrl and sss_datapath.
//
// Usage:
//   A command beat (req_command, req_room) is taken at a rising edge where
//   start is high and busy is low. busy stays high while the command runs.
//   Exactly one result beat follows each command: rsp_valid is high for one
//   cycle with rsp_present, rsp_changed, rsp_count and rsp_status; it is
//   taken at the edge that ends that cycle. There is no backpressure.
//   Clear, ignored save/restore and unused codes give the result in the cycle
//   after the accept. Add, remove, toggle and query scan the list entry by
//   entry (registered RAM read, then compare); remove, and a toggle that
//   removes, then shift later entries down one place; save and restore copy
//   entry by entry. The single read port of the list RAM sets the pace of
//   these passes.
//   busy drops in the result cycle, so the next command may be given then.
//   Reset (synchronous, active high) empties the list and drops any pending
//   snapshot; RAM contents are not cleared and need no clearing pass.
module selection_set_with_snapshot_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [sss_pkg::CMD_BITS-1:0]     req_command,
   input  logic [sss_pkg::ROOM_BITS-1:0]    req_room,
   output logic                             rsp_valid,
   output logic                             rsp_present,
   output logic                             rsp_changed,
   output logic [sss_pkg::COUNT_BITS-1:0]   rsp_count,
   output logic                             rsp_status
);
   import sss_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   sss_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .command(op_type'(req_command)),
      .status (dp_status),
      .busy   (busy),
      .cmd    (dp_cmd)
   );

   sss_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_command(req_command),
      .req_room   (req_room),
      .cmd        (dp_cmd),
      .status     (dp_status),
      .rsp_valid  (rsp_valid),
      .rsp_present(rsp_present),
      .rsp_changed(rsp_changed),
      .rsp_count  (rsp_count),
      .rsp_status (rsp_status)
   );

`ifndef NO_ASSERTIONS
   a_no_result_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result beat while busy");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_count <= COUNT_BITS'(LIST_DEPTH))
      else $error("count beyond list depth");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> !rsp_present && rsp_count == COUNT_BITS'(LIST_DEPTH))
      else $error("full flag without a full list");

   a_clear_result: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_command == OP_CLEAR |=>
         rsp_valid && rsp_changed && rsp_count == '0)
      else $error("clear result wrong");
`endif

endmodule

[tb/selection_tracker_pkg.sv]
`timescale 1ns / 1ps
// Scoreboard for the selection set testbench: keeps its own copy of the list and
// snapshot, predicts each result beat and checks what the block returns. Uses sss_pkg.
package selection_tracker_pkg;
   import sss_pkg::*;

   typedef struct packed {
      logic                  present;
      logic                  changed;
      logic [COUNT_BITS-1:0] count;
      logic                  status;
   } sel_result_type;

   class selection_tracker;
      logic [ID_BITS-1:0] list_ids  [LIST_DEPTH];
      logic [ID_BITS-1:0] saved_ids [LIST_DEPTH];
      int                 list_len;
      int                 saved_len;
      bit                 snap_held;
      sel_result_type     expected_q [$];
      int                 errors;
      int                 beats_checked;
      int                 commands_noted;
      int                 full_drops;
      int                 peak_len;
      int                 saves_taken;

      function new();
         list_len       = 0;
         saved_len      = 0;
         snap_held      = 1'b0;
         errors         = 0;
         beats_checked  = 0;
         commands_noted = 0;
         full_drops     = 0;
         peak_len       = 0;
         saves_taken    = 0;
      endfunction

      function int outstanding();
         return expected_q.size();
      endfunction

      // position of id in the list, -1 when absent
      function int find_pos(logic [ID_BITS-1:0] id);
         for (int i = 0; i < list_len; i++)
            if (list_ids[i] == id) return i;
         return -1;
      endfunction

      function void drop_at(int pos);
         for (int j = pos; j + 1 < list_len; j++) list_ids[j] = list_ids[j + 1];
         list_len--;
      endfunction

      function bit append_id(logic [ID_BITS-1:0] id);
         if (list_len >= LIST_DEPTH) return 1'b0;
         list_ids[list_len] = id;
         list_len++;
         return 1'b1;
      endfunction

      function void note_command(logic [CMD_BITS-1:0] cmd, logic [ROOM_BITS-1:0] room);
         sel_result_type     res;
         logic [ID_BITS-1:0] id;
         int                 pos;
         res = '0;
         id  = room[ID_BITS-1:0];
         commands_noted++;
         case (cmd)
            OP_CLEAR: begin
               list_len    = 0;
               res.changed = 1'b1;
            end
            OP_ADD: begin
               if (find_pos(id) >= 0) begin
                  res.present = 1'b1;
               end else if (append_id(id)) begin
                  res.present = 1'b1;
                  res.changed = 1'b1;
               end else begin
                  res.status = 1'b1;
               end
            end
            OP_REMOVE: begin
               pos = find_pos(id);
               if (pos >= 0) begin
                  drop_at(pos);
                  res.changed = 1'b1;
               end
            end
            OP_TOGGLE: begin
               res.changed = 1'b1;
               pos = find_pos(id);
               if (pos >= 0) drop_at(pos);
               else if (append_id(id)) res.present = 1'b1;
               else res.status = 1'b1;
            end
            OP_QUERY: res.present = (find_pos(id) >= 0);
            OP_SAVE: begin
               if (!snap_held) begin
                  saved_len = list_len;
                  for (int i = 0; i < saved_len; i++) saved_ids[i] = list_ids[i];
                  snap_held = 1'b1;
                  saves_taken++;
               end
            end
            OP_RESTORE: begin
               if (snap_held) begin
                  list_len = saved_len;
                  for (int i = 0; i < list_len; i++) list_ids[i] = saved_ids[i];
                  snap_held = 1'b0;
               end
            end
            default: ;
         endcase
         res.count = list_len[COUNT_BITS-1:0];
         if (res.status) full_drops++;
         if (list_len > peak_len) peak_len = list_len;
         expected_q.push_back(res);
      endfunction

      function void check_result(logic present, logic changed,
                                 logic [COUNT_BITS-1:0] count, logic status);
         sel_result_type want;
         string          diff;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result beat: present=%0d changed=%0d count=%0d status=%0d",
                        present, changed, count, status);
            return;
         end
         want = expected_q.pop_front();
         beats_checked++;
         diff = "";
         if (present !== want.present) diff = {diff, " present"};
         if (changed !== want.changed) diff = {diff, " changed"};
         if (count !== want.count) diff = {diff, " count"};
         if (status !== want.status) diff = {diff, " status"};
         if (diff != "") begin
            errors++;
            if (errors <= 10)
               $display({"beat %0d mismatch on%s: want p=%0d c=%0d n=%0d s=%0d,",
                         " got p=%0d c=%0d n=%0d s=%0d"},
                        beats_checked, diff, want.present, want.changed, want.count, want.status,
                        present, changed, count, status);
         end
      endfunction
   endclass

endpackage

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Testbench top for selection_set_with_snapshot_top: directed, fill-to-full and random
// command beats, checked by selection_tracker. Uses sss_pkg and selection_tracker_pkg.
module tb_top;
   import sss_pkg::*;
   import selection_tracker_pkg::*;

   localparam logic [CMD_BITS-1:0] CMD_UNUSED = 3'd7;
   localparam int CYCLE_LIMIT  = 1_500_000;
   localparam int ITEM_TARGET  = 650;
   localparam int DRAIN_CYCLES = 600;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [CMD_BITS-1:0]   req_command;
   logic [ROOM_BITS-1:0]  req_room;
   logic                  rsp_valid;
   logic                  rsp_present;
   logic                  rsp_changed;
   logic [COUNT_BITS-1:0] rsp_count;
   logic                  rsp_status;

   selection_tracker tracker;
   int               cycles = 0;
   int               items_sent = 0;
   bit               idle_on = 1'b1;

   selection_set_with_snapshot_top u_top (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_command (req_command),
      .req_room    (req_room),
      .rsp_valid   (rsp_valid),
      .rsp_present (rsp_present),
      .rsp_changed (rsp_changed),
      .rsp_count   (rsp_count),
      .rsp_status  (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("[selection_set_with_snapshot_top] ERROR");
         $finish;
      end
   end

   // result of an earlier beat is checked before a new command is noted
   always @(posedge clock) begin
      if (reset === 1'b0) begin
         if (rsp_valid === 1'b1)
            tracker.check_result(rsp_present, rsp_changed, rsp_count, rsp_status);
         if (start === 1'b1 && busy === 1'b0)
            tracker.note_command(req_command, req_room);
      end
   end

   task automatic issue(input logic [CMD_BITS-1:0] cmd, input logic [ROOM_BITS-1:0] room);
      int gap;
      req_command <= cmd;
      req_room    <= room;
      start       <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      items_sent++;
      gap = 0;
      if (idle_on && $urandom_range(0, 99) < 30)
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // drop start and wait for the clock first so the last accepted beat is already noted
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (tracker.outstanding() != 0) @(posedge clock);
   endtask

   function automatic logic [ROOM_BITS-1:0] pick_room();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return ROOM_BITS'($urandom_range(0, 47));
      if (r < 90) return ROOM_BITS'($urandom_range(0, 1023));
      if (r < 95) return '0;
      return '1;
   endfunction

   function automatic logic [CMD_BITS-1:0] pick_cmd();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return OP_ADD;
      if (r < 45) return OP_REMOVE;
      if (r < 60) return OP_TOGGLE;
      if (r < 80) return OP_QUERY;
      if (r < 88) return OP_SAVE;
      if (r < 96) return OP_RESTORE;
      if (r < 98) return OP_CLEAR;
      return CMD_UNUSED;
   endfunction

   initial begin
      logic [ROOM_BITS-1:0] base;
      logic [ROOM_BITS-1:0] step;
      logic [ROOM_BITS-1:0] fresh;
      tracker     = new();
      start       <= 1'b0;
      req_command <= OP_CLEAR;
      req_room    <= '0;
      reset       <= 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: empty list, snapshot corner cases, extremes, order after removal
      issue(OP_QUERY, 10'd0);
      issue(OP_REMOVE, 10'd5);
      issue(OP_RESTORE, 10'd0);
      issue(OP_SAVE, 10'd0);
      issue(OP_SAVE, 10'd1023);
      issue(OP_RESTORE, 10'd0);
      issue(CMD_UNUSED, 10'd1023);
      issue(OP_ADD, 10'd0);
      issue(OP_ADD, 10'd1023);
      issue(OP_ADD, 10'd0);
      issue(OP_QUERY, 10'd1023);
      issue(OP_TOGGLE, 10'd512);
      issue(OP_TOGGLE, 10'd512);
      issue(OP_ADD, 10'd341);
      issue(OP_ADD, 10'd682);
      issue(OP_SAVE, 10'd0);
      issue(OP_CLEAR, 10'd682);
      issue(OP_QUERY, 10'd341);
      issue(OP_RESTORE, 10'd0);
      issue(OP_REMOVE, 10'd1023);
      issue(OP_QUERY, 10'd682);
      issue(OP_TOGGLE, 10'd7);
      issue(OP_REMOVE, 10'd7);
      issue(CMD_UNUSED, 10'd0);

      // fill to full with distinct ids (odd stride), no idling for a long stretch
      base = ROOM_BITS'($urandom_range(0, 1023));
      step = ROOM_BITS'(($urandom_range(0, 511) << 1) | 1);
      issue(OP_CLEAR, ROOM_BITS'($urandom_range(0, 1023)));
      idle_on = 1'b0;
      for (int k = 0; k < LIST_DEPTH; k++) begin
         if (k == 160) idle_on = 1'b1;
         issue(OP_ADD, ROOM_BITS'(base + k * step));
         if ($urandom_range(0, 9) == 0) issue(OP_QUERY, pick_room());
         else if ($urandom_range(0, 19) == 0)
            issue(OP_ADD, ROOM_BITS'(base + $urandom_range(0, k) * step));
      end

      // full list: drops, hits, ends of the list, snapshot of a full list
      fresh = ROOM_BITS'(base + (LIST_DEPTH + $urandom_range(0, 767)) * step);
      issue(OP_ADD, fresh);
      issue(OP_TOGGLE, fresh);
      issue(OP_QUERY, base);
      issue(OP_ADD, ROOM_BITS'(base + 255 * step));
      issue(OP_SAVE, ROOM_BITS'($urandom_range(0, 1023)));
      issue(OP_REMOVE, ROOM_BITS'(base + 128 * step));
      issue(OP_TOGGLE, fresh);
      issue(OP_ADD, ROOM_BITS'(fresh + step * LIST_DEPTH));
      issue(OP_REMOVE, base);
      issue(OP_REMOVE, fresh);
      issue(OP_REMOVE, ROOM_BITS'(base + 255 * step));
      issue(OP_RESTORE, ROOM_BITS'($urandom_range(0, 1023)));
      issue(OP_QUERY, fresh);
      issue(OP_TOGGLE, ROOM_BITS'(base + 7 * step));
      issue(OP_TOGGLE, ROOM_BITS'(base + 7 * step));
      issue(OP_TOGGLE, fresh);

      wait_drained();
      issue(OP_CLEAR, ROOM_BITS'($urandom_range(0, 1023)));

      while (items_sent < ITEM_TARGET) issue(pick_cmd(), pick_room());

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d commands sent, %0d result beats checked; list peaked at %0d entries,",
               items_sent, tracker.beats_checked, tracker.peak_len);
      $display("%0d adds/toggles dropped on a full list, %0d snapshots taken",
               tracker.full_drops, tracker.saves_taken);
      if (tracker.errors == 0 && tracker.outstanding() == 0) begin
         $display("[selection_set_with_snapshot_top] OK");
      end else begin
         $display("%0d errors, %0d results never arrived", tracker.errors, tracker.outstanding());
         $display("[selection_set_with_snapshot_top] ERROR");
      end
      $finish;
   end

endmodule

[sim.f]
design/sss_pkg.sv
design/sss_ram.sv
design/sss_ctrl.sv
design/sss_datapath.sv
design/selection_set_with_snapshot_top.sv
tb/selection_tracker_pkg.sv
tb/tb_top.sv
